// ----- src/assert_macros.svh -----
// shared assertion macros, clocked on aclk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLPTS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/slpts_pkg.sv -----
package slpts_pkg;

    localparam int LINE_BUFFER_BYTES = 32;
    localparam int LINE_COUNT_W      = $clog2(LINE_BUFFER_BYTES);
    localparam int LINE_KEEP_MAX     = LINE_BUFFER_BYTES - 1;
    localparam int PREFIX_LEN        = 6;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [15:0] MAG_LIMIT = 16'd32768;
    localparam logic [15:0] POS_MAX   = 16'd32767;

    // tier codes as seen on the result port
    localparam logic [1:0] TIER_CODE_SLOW = 2'd0;
    localparam logic [1:0] TIER_CODE_CITY = 2'd1;
    localparam logic [1:0] TIER_CODE_HWY  = 2'd2;

    localparam logic [1:0]  BLE_SLOW  = 2'd3;
    localparam logic [1:0]  BLE_CITY  = 2'd2;
    localparam logic [1:0]  BLE_HWY   = 2'd1;
    localparam logic [12:0] WIFI_SLOW = 13'd5000;
    localparam logic [12:0] WIFI_CITY = 13'd3000;
    localparam logic [12:0] WIFI_HWY  = 13'd1500;

    // configuration register indexes
    localparam logic [1:0] CFG_HWY_ENTER  = 2'd0;
    localparam logic [1:0] CFG_HWY_EXIT   = 2'd1;
    localparam logic [1:0] CFG_SLOW_ENTER = 2'd2;
    localparam logic [1:0] CFG_SLOW_EXIT  = 2'd3;

    localparam logic [7:0] HWY_ENTER_RST  = 8'd43;
    localparam logic [7:0] HWY_EXIT_RST   = 8'd38;
    localparam logic [7:0] SLOW_ENTER_RST = 8'd4;
    localparam logic [7:0] SLOW_EXIT_RST  = 8'd8;

    typedef struct packed {
        logic line_complete;
        logic speed_updated;
    } line_status_t;

    function automatic logic [7:0] speed_prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h53; // S
            3'd1:    ch = 8'h50; // P
            3'd2:    ch = 8'h45; // E
            3'd3:    ch = 8'h45; // E
            3'd4:    ch = 8'h44; // D
            3'd5:    ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/speed_line_parser_tier_select.sv -----
// channel | signals                                       | dir
// input   | s_valid s_ready s_func s_rx_byte              | in
// result  | m_valid m_ready m_speed_mph m_tier            | out
//         | m_ble_scan_seconds m_wifi_scan_ms             |
//         | m_line_complete m_speed_updated               |
// config  | cfg_we cfg_index cfg_data                     | in
//
// one item per cycle sustained while m_ready stays high; two register stages, input then result
// an accepted item is held in the input register, then in the result register, and shows on the result port
// the input register feeds one pass of parser and tier logic into the result register
// aresetn is synchronous, active low; thresholds return to 43/38/4/8, tier to city
// a stalled result holds while one more item waits in the input register
module speed_line_parser_tier_select (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_speed_mph,
    output logic [1:0]         m_tier,
    output logic [1:0]         m_ble_scan_seconds,
    output logic [12:0]        m_wifi_scan_ms,
    output logic               m_line_complete,
    output logic               m_speed_updated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    `include "assert_macros.svh"

    // input register
    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic                    out_valid_reg;
    logic signed [15:0]      out_speed_reg;
    logic [1:0]              out_tier_reg;
    logic [1:0]              out_ble_reg;
    logic [12:0]             out_wifi_reg;
    slpts_pkg::line_status_t out_status_reg;

    logic                    advance;
    logic signed [15:0]      speed_cur, speed_next;
    slpts_pkg::line_status_t status_next;
    logic [1:0]              tier_next, ble_next;
    logic [12:0]             wifi_next;

    // the item in the input register moves on when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_rx_byte;
        end
    end

    // byte path: line buffer bookkeeping and number parse
    slpts_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance && !in_func_reg),
        .rx_byte     (in_byte_reg),
        .speed_mph   (speed_cur),
        .speed_next  (speed_next),
        .line_status (status_next)
    );

    // tick path: hysteresis step and scan durations
    slpts_tier u_tier (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (advance && in_func_reg),
        .speed_mph (speed_cur),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tier_next (tier_next),
        .ble_next  (ble_next),
        .wifi_next (wifi_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // a tick leaves the speed and line flags quiet
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_speed_reg  <= in_func_reg ? speed_cur : speed_next;
            out_tier_reg   <= tier_next;
            out_ble_reg    <= ble_next;
            out_wifi_reg   <= wifi_next;
            out_status_reg <= in_func_reg ? '0 : status_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_speed_mph        = out_speed_reg;
    assign m_tier             = out_tier_reg;
    assign m_ble_scan_seconds = out_ble_reg;
    assign m_wifi_scan_ms     = out_wifi_reg;
    assign m_line_complete    = out_status_reg.line_complete;
    assign m_speed_updated    = out_status_reg.speed_updated;

    `SLPTS_ASSERT(a_update_needs_line, m_valid && m_speed_updated, m_line_complete, "speed update without line end")
    `SLPTS_ASSERT(a_tier_code_valid, m_valid, m_tier != 2'd3, "unused tier code on result")
    `SLPTS_ASSERT(a_hwy_scan, m_valid && m_tier == slpts_pkg::TIER_CODE_HWY, m_ble_scan_seconds == slpts_pkg::BLE_HWY && m_wifi_scan_ms == slpts_pkg::WIFI_HWY, "highway scan mismatch")
    `SLPTS_ASSERT(a_stall_has_item, !s_ready, in_valid_reg && out_valid_reg, "input stalled with free slot")
    `SLPTS_ASSERT_NEXT(a_advance_shows, advance, m_valid, "advanced item missing on result")

endmodule

// ----- src/slpts_parser.sv -----
module slpts_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  logic [7:0]                rx_byte,
    output logic signed [15:0]        speed_mph,
    output logic signed [15:0]        speed_next,
    output slpts_pkg::line_status_t   line_status
);

    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    logic [slpts_pkg::LINE_COUNT_W-1:0] line_count_reg, line_count_next;
    logic                               prefix_ok_reg, prefix_ok_next;
    phase_t                             phase_reg, phase_next;
    logic                               negative_reg, negative_next;
    logic [15:0]                        mag_reg, mag_next;
    logic                               zero_seen_reg, zero_seen_next;
    logic signed [15:0]                 speed_reg;

    logic        is_space, is_digit, is_sign, in_prefix;
    logic [19:0] mag_times_ten;
    logic [16:0] neg_mag;

    assign is_space  = (rx_byte == slpts_pkg::CHAR_SPACE) ||
                       (rx_byte >= slpts_pkg::CHAR_TAB && rx_byte <= slpts_pkg::CHAR_CR);
    assign is_digit  = (rx_byte >= slpts_pkg::CHAR_ZERO) && (rx_byte <= slpts_pkg::CHAR_NINE);
    assign is_sign   = (rx_byte == slpts_pkg::CHAR_PLUS) || (rx_byte == slpts_pkg::CHAR_MINUS);
    assign in_prefix = line_count_reg < slpts_pkg::LINE_COUNT_W'(slpts_pkg::PREFIX_LEN);
    assign mag_times_ten = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                         + {12'd0, rx_byte - slpts_pkg::CHAR_ZERO};
    assign neg_mag = 17'd0 - {1'b0, mag_reg};

    always_comb begin
        line_count_next = line_count_reg;
        prefix_ok_next  = prefix_ok_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        mag_next        = mag_reg;
        zero_seen_next  = zero_seen_reg;
        speed_next      = speed_reg;
        line_status     = '0;

        if (rx_byte == slpts_pkg::CHAR_LF) begin
            line_status.line_complete = 1'b1;
            if (prefix_ok_reg && !in_prefix) begin
                line_status.speed_updated = 1'b1;
                if (negative_reg) begin
                    speed_next = neg_mag[15:0];
                end else if (mag_reg > slpts_pkg::POS_MAX) begin
                    speed_next = slpts_pkg::POS_MAX;
                end else begin
                    speed_next = mag_reg;
                end
            end
            line_count_next = '0;
            prefix_ok_next  = 1'b1;
            phase_next      = PH_SPACE;
            negative_next   = 1'b0;
            mag_next        = '0;
            zero_seen_next  = 1'b0;
        end else if (rx_byte != slpts_pkg::CHAR_CR &&
                     line_count_reg < slpts_pkg::LINE_COUNT_W'(slpts_pkg::LINE_KEEP_MAX)) begin
            line_count_next = line_count_reg + 1'b1;
            if (zero_seen_reg) begin
                // text after a zero byte is dead
            end else if (rx_byte == slpts_pkg::CHAR_NUL) begin
                zero_seen_next = 1'b1;
                if (in_prefix) begin
                    prefix_ok_next = 1'b0;
                end
            end else if (in_prefix) begin
                if (rx_byte != slpts_pkg::speed_prefix_char(line_count_reg[2:0])) begin
                    prefix_ok_next = 1'b0;
                end
            end else if (phase_reg != PH_DONE) begin
                if (phase_reg == PH_SPACE && is_space) begin
                    // skip leading white space
                end else if (phase_reg == PH_SPACE && is_sign) begin
                    negative_next = (rx_byte == slpts_pkg::CHAR_MINUS);
                    phase_next    = PH_SIGN;
                end else if (is_digit) begin
                    mag_next   = (mag_times_ten > {4'd0, slpts_pkg::MAG_LIMIT}) ?
                                 slpts_pkg::MAG_LIMIT : mag_times_ten[15:0];
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= '0;
            prefix_ok_reg  <= 1'b1;
            phase_reg      <= PH_SPACE;
            negative_reg   <= 1'b0;
            mag_reg        <= '0;
            zero_seen_reg  <= 1'b0;
            speed_reg      <= '0;
        end else if (step_en) begin
            line_count_reg <= line_count_next;
            prefix_ok_reg  <= prefix_ok_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            mag_reg        <= mag_next;
            zero_seen_reg  <= zero_seen_next;
            speed_reg      <= speed_next;
        end
    end

    assign speed_mph = speed_reg;

endmodule

// ----- src/slpts_tier.sv -----
module slpts_tier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick_en,
    input  logic signed [15:0] speed_mph,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output logic [1:0]         tier_next,
    output logic [1:0]         ble_next,
    output logic [12:0]        wifi_next
);

    typedef enum logic [2:0] {
        TIER_SLOW = 3'b001,
        TIER_CITY = 3'b010,
        TIER_HWY  = 3'b100
    } tier_t;

    tier_t      tier_reg, tier_state_next, tier_stepped;
    logic [7:0] hwy_enter_reg, hwy_exit_reg, slow_enter_reg, slow_exit_reg;

    logic ge_hwy_enter, le_hwy_exit, le_slow_enter, ge_slow_exit;

    assign ge_hwy_enter  = speed_mph >= $signed({8'd0, hwy_enter_reg});
    assign le_hwy_exit   = speed_mph <= $signed({8'd0, hwy_exit_reg});
    assign le_slow_enter = speed_mph <= $signed({8'd0, slow_enter_reg});
    assign ge_slow_exit  = speed_mph >= $signed({8'd0, slow_exit_reg});

    always_comb begin
        tier_stepped = tier_reg;
        case (tier_reg)
            TIER_CITY: begin
                if (ge_hwy_enter) begin
                    tier_stepped = TIER_HWY;
                end else if (le_slow_enter) begin
                    tier_stepped = TIER_SLOW;
                end
            end
            TIER_HWY: begin
                if (le_hwy_exit) begin
                    tier_stepped = TIER_CITY;
                end
            end
            TIER_SLOW: begin
                if (ge_slow_exit) begin
                    tier_stepped = TIER_CITY;
                end
            end
            default: tier_stepped = tier_reg;
        endcase
        tier_state_next = tick_en ? tier_stepped : tier_reg;
    end

    always_comb begin
        case (tier_state_next)
            TIER_HWY: begin
                tier_next = slpts_pkg::TIER_CODE_HWY;
                ble_next  = slpts_pkg::BLE_HWY;
                wifi_next = slpts_pkg::WIFI_HWY;
            end
            TIER_CITY: begin
                tier_next = slpts_pkg::TIER_CODE_CITY;
                ble_next  = slpts_pkg::BLE_CITY;
                wifi_next = slpts_pkg::WIFI_CITY;
            end
            default: begin
                tier_next = slpts_pkg::TIER_CODE_SLOW;
                ble_next  = slpts_pkg::BLE_SLOW;
                wifi_next = slpts_pkg::WIFI_SLOW;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tier_reg <= TIER_CITY;
        end else begin
            tier_reg <= tier_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwy_enter_reg  <= slpts_pkg::HWY_ENTER_RST;
            hwy_exit_reg   <= slpts_pkg::HWY_EXIT_RST;
            slow_enter_reg <= slpts_pkg::SLOW_ENTER_RST;
            slow_exit_reg  <= slpts_pkg::SLOW_EXIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                slpts_pkg::CFG_HWY_ENTER:  hwy_enter_reg  <= cfg_data;
                slpts_pkg::CFG_HWY_EXIT:   hwy_exit_reg   <= cfg_data;
                slpts_pkg::CFG_SLOW_ENTER: slow_enter_reg <= cfg_data;
                slpts_pkg::CFG_SLOW_EXIT:  slow_exit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- verif/slpts_tb_pkg.sv -----
`timescale 1ns / 100ps

package slpts_tb_pkg;

    // what one input item asks of the block
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

endpackage

// ----- verif/speed_tier_checker.sv -----
`timescale 1ns / 100ps

module speed_tier_checker
    import slpts_pkg::*;
    import slpts_tb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_func,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_speed_mph,
    input  logic [1:0]         m_tier,
    input  logic [1:0]         m_ble_scan_seconds,
    input  logic [12:0]        m_wifi_scan_ms,
    input  logic               m_line_complete,
    input  logic               m_speed_updated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output int                 mismatches,
    output int                 pending
);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } num_phase_t;

    typedef struct packed {
        logic [15:0] speed;
        logic [1:0]  tier;
        logic [1:0]  ble;
        logic [12:0] wifi;
        logic        line_done;
        logic        speed_set;
    } tier_report_t;

    localparam logic [7:0] SPEED_TAG [0:5] = '{8'h53, 8'h50, 8'h45, 8'h45, 8'h44, 8'h3A};

    // thresholds
    logic [7:0] hwy_enter, hwy_exit, slow_enter, slow_exit;

    // line state
    logic [4:0]  kept_len;
    logic        tag_ok;
    num_phase_t  phase;
    logic        minus;
    logic [15:0] mag;
    logic        nul_seen;

    logic signed [15:0] speed_now;
    logic [1:0]         tier_now;

    tier_report_t tier_reports_due [$];
    int fail_count;
    int results_seen;

    assign mismatches = fail_count;

    task automatic flag_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got,
                 want);
    endtask

    task automatic clear_line_state();
        kept_len = '0;
        tag_ok   = 1'b1;
        phase    = PH_SPACE;
        minus    = 1'b0;
        mag      = '0;
        nul_seen = 1'b0;
    endtask

    task automatic parse_number_char(input logic [7:0] ch);
        logic        is_space;
        logic        is_digit;
        logic [19:0] grown;
        is_space = (ch == CHAR_SPACE) || (ch >= CHAR_TAB && ch <= CHAR_CR);
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        if (phase != PH_DONE) begin
            if (phase == PH_SPACE && is_space) begin
                // leading blanks skipped
            end else if (phase == PH_SPACE && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
                minus = (ch == CHAR_MINUS);
                phase = PH_SIGN;
            end else if (is_digit) begin
                grown = mag * 10 + (ch - CHAR_ZERO);
                if (grown > MAG_LIMIT)
                    grown = MAG_LIMIT;
                mag   = grown[15:0];
                phase = PH_DIGITS;
            end else begin
                phase = PH_DONE;
            end
        end
    endtask

    task automatic keep_char(input logic [7:0] ch);
        logic [4:0] pos;
        pos      = kept_len;
        kept_len = kept_len + 5'd1;
        if (!nul_seen) begin
            if (ch == CHAR_NUL) begin
                nul_seen = 1'b1;
                if (pos < PREFIX_LEN)
                    tag_ok = 1'b0;
            end else if (pos < PREFIX_LEN) begin
                if (ch != SPEED_TAG[pos])
                    tag_ok = 1'b0;
            end else begin
                parse_number_char(ch);
            end
        end
    endtask

    task automatic tier_hysteresis_step();
        int s;
        int he, hx, se, sx;
        s  = speed_now;
        he = hwy_enter;
        hx = hwy_exit;
        se = slow_enter;
        sx = slow_exit;
        case (tier_now)
            TIER_CODE_CITY: begin
                if (s >= he)
                    tier_now = TIER_CODE_HWY;
                else if (s <= se)
                    tier_now = TIER_CODE_SLOW;
            end
            TIER_CODE_HWY: begin
                if (s <= hx)
                    tier_now = TIER_CODE_CITY;
            end
            TIER_CODE_SLOW: begin
                if (s >= sx)
                    tier_now = TIER_CODE_CITY;
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_tier_report(input op_t op, input logic [7:0] ch,
                                       output tier_report_t rep);
        rep.line_done = 1'b0;
        rep.speed_set = 1'b0;
        if (op == OP_TICK) begin
            tier_hysteresis_step();
        end else if (ch == CHAR_LF) begin
            rep.line_done = 1'b1;
            if (tag_ok && kept_len >= PREFIX_LEN) begin
                if (minus)
                    speed_now = ~mag + 16'd1;
                else
                    speed_now = (mag > POS_MAX) ? POS_MAX : mag;
                rep.speed_set = 1'b1;
            end
            clear_line_state();
        end else if (ch != CHAR_CR && kept_len < LINE_KEEP_MAX) begin
            keep_char(ch);
        end
        rep.speed = speed_now;
        rep.tier  = tier_now;
        case (tier_now)
            TIER_CODE_HWY: begin
                rep.ble  = BLE_HWY;
                rep.wifi = WIFI_HWY;
            end
            TIER_CODE_CITY: begin
                rep.ble  = BLE_CITY;
                rep.wifi = WIFI_CITY;
            end
            default: begin
                rep.ble  = BLE_SLOW;
                rep.wifi = WIFI_SLOW;
            end
        endcase
    endtask

    initial begin
        fail_count   = 0;
        results_seen = 0;
        pending      = 0;
    end

    always @(posedge aclk) begin
        tier_report_t got_rep;
        tier_report_t want;
        if (!aresetn) begin
            hwy_enter  = HWY_ENTER_RST;
            hwy_exit   = HWY_EXIT_RST;
            slow_enter = SLOW_ENTER_RST;
            slow_exit  = SLOW_EXIT_RST;
            clear_line_state();
            speed_now = '0;
            tier_now  = TIER_CODE_CITY;
            tier_reports_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HWY_ENTER:  hwy_enter  = cfg_data;
                    CFG_HWY_EXIT:   hwy_exit   = cfg_data;
                    CFG_SLOW_ENTER: slow_enter = cfg_data;
                    CFG_SLOW_EXIT:  slow_exit  = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (tier_reports_due.size() == 0) begin
                    flag_mismatch("result with nothing expected, speed", m_speed_mph, 0);
                end else begin
                    want = tier_reports_due.pop_front();
                    if (m_speed_mph !== want.speed)
                        flag_mismatch("speed_mph", m_speed_mph, $signed(want.speed));
                    if (m_tier !== want.tier)
                        flag_mismatch("tier", m_tier, want.tier);
                    if (m_ble_scan_seconds !== want.ble)
                        flag_mismatch("ble_scan_seconds", m_ble_scan_seconds, want.ble);
                    if (m_wifi_scan_ms !== want.wifi)
                        flag_mismatch("wifi_scan_ms", m_wifi_scan_ms, want.wifi);
                    if (m_line_complete !== want.line_done)
                        flag_mismatch("line_complete", m_line_complete, want.line_done);
                    if (m_speed_updated !== want.speed_set)
                        flag_mismatch("speed_updated", m_speed_updated, want.speed_set);
                end
            end
            if (s_valid && s_ready) begin
                predict_tier_report(op_t'(s_func), s_rx_byte, got_rep);
                tier_reports_due.push_back(got_rep);
            end
        end
        pending <= tier_reports_due.size();
    end

endmodule

// ----- verif/tb_speed_line_parser_tier_select.sv -----
`timescale 1ns / 100ps

module tb_speed_line_parser_tier_select;
    import slpts_pkg::*;
    import slpts_tb_pkg::*;

    // blank characters the parser skips that the package does not name
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;

    localparam int RANDOM_ITEMS    = 1600;
    localparam int PHASES          = 5;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int CYCLE_LIMIT     = 300000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_speed_mph;
    logic [1:0]         m_tier;
    logic [1:0]         m_ble_scan_seconds;
    logic [12:0]        m_wifi_scan_ms;
    logic               m_line_complete;
    logic               m_speed_updated;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;

    int mismatches;
    int pending;

    // sender bookkeeping
    int items_sent;
    int burst_left;
    logic [7:0] line_buf [$];

    // long receiver hold-offs asked for by the stimulus, served by the receiver process
    int hold_offs_wanted;
    int hold_offs_done;
    int cycles;

    speed_line_parser_tier_select uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_speed_mph        (m_speed_mph),
        .m_tier             (m_tier),
        .m_ble_scan_seconds (m_ble_scan_seconds),
        .m_wifi_scan_ms     (m_wifi_scan_ms),
        .m_line_complete    (m_line_complete),
        .m_speed_updated    (m_speed_updated),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // watches both channels and the config port, predicts and compares
    speed_tier_checker tier_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_speed_mph        (m_speed_mph),
        .m_tier             (m_tier),
        .m_ble_scan_seconds (m_ble_scan_seconds),
        .m_wifi_scan_ms     (m_wifi_scan_ms),
        .m_line_complete    (m_line_complete),
        .m_speed_updated    (m_speed_updated),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .pending            (pending)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // offer one item and hold it until the block takes it
    // bursts of random length, each preceded by a random gap (sometimes none)
    task automatic push_item(input op_t op, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_func    <= op;
        s_rx_byte <= ch;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    function automatic void append_str(input string txt);
        for (int i = 0; i < txt.len(); i++)
            line_buf.push_back(txt[i]);
    endfunction

    // send the buffered line, now and then slipping a tick in between bytes
    task automatic send_line_buf();
        foreach (line_buf[i]) begin
            if ($urandom_range(0, 24) == 0)
                push_item(OP_TICK, 8'($urandom_range(0, 255)));
            push_item(OP_BYTE, line_buf[i]);
        end
        line_buf.delete();
    endtask

    // text after the prefix: blanks, sign, digits, trailing junk
    task automatic append_number_text();
        int pick;
        if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0:       line_buf.push_back(CHAR_SPACE);
                    1:       line_buf.push_back(CHAR_TAB);
                    2:       line_buf.push_back(CHAR_VT);
                    default: line_buf.push_back(CHAR_FF);
                endcase
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            line_buf.push_back(CHAR_MINUS);
        else if (pick < 25)
            line_buf.push_back(CHAR_PLUS);
        if ($urandom_range(0, 9) == 0)
            line_buf.push_back(CHAR_ZERO);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // around the default thresholds
            append_str($sformatf("%0d", $urandom_range(0, 60)));
        end else if (pick < 75) begin
            append_str($sformatf("%0d", $urandom_range(0, 300)));
        end else if (pick < 90) begin
            // long digit runs, mostly past the 16-bit range
            repeat ($urandom_range(5, 12))
                line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        // otherwise no digits at all
        if ($urandom_range(0, 4) == 0)
            append_str(" mph");
    endtask

    task automatic send_random_line();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        line_buf.delete();
        if (kind < 60) begin
            append_str("SPEED:");
            append_number_text();
        end else if (kind < 70) begin
            // prefix with one character spoiled
            append_str("SPEED:");
            line_buf[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            append_number_text();
        end else if (kind < 77) begin
            // too short to carry the whole prefix
            n = $urandom_range(0, 5);
            append_str("SPEED:");
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end else if (kind < 84) begin
            // zero byte somewhere in an otherwise good line
            append_str("SPEED:");
            append_number_text();
            line_buf.insert($urandom_range(0, line_buf.size() - 1), CHAR_NUL);
        end else if (kind < 92) begin
            // runs into the line length cap, digits may land past it
            append_str("SPEED:");
            repeat ($urandom_range(10, 34))
                line_buf.push_back(CHAR_SPACE);
            append_number_text();
            repeat ($urandom_range(0, 10))
                line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else begin
            // raw noise
            repeat ($urandom_range(1, 12))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) == 0 && line_buf.size() > 0)
            line_buf.insert($urandom_range(0, line_buf.size() - 1), CHAR_CR);
        if ($urandom_range(0, 2) == 0)
            line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
        send_line_buf();
    endtask

    // stop offering and wait until every expected item has come back
    task automatic quiesce();
        s_valid    <= 1'b0;
        burst_left = 0;
        do
            @(posedge aclk);
        while (pending != 0);
        // margin for the pipeline to settle
        repeat (4) @(posedge aclk);
    endtask

    // new thresholds, only while the block is idle
    task automatic retune(input logic [7:0] hwy_in, hwy_out, slow_in, slow_out);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HWY_ENTER;
        cfg_data  <= hwy_in;
        @(posedge aclk);
        cfg_index <= CFG_HWY_EXIT;
        cfg_data  <= hwy_out;
        @(posedge aclk);
        cfg_index <= CFG_SLOW_ENTER;
        cfg_data  <= slow_in;
        @(posedge aclk);
        cfg_index <= CFG_SLOW_EXIT;
        cfg_data  <= slow_out;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: segments of always-ready, coin-flip, mostly-ready and periodic mostly-stalling
    // behaviour, interrupted by long hold-offs when the stimulus asks for them
    initial begin
        int seg_left;
        int style;
        m_ready        <= 1'b0;
        hold_offs_done = 0;
        seg_left       = 0;
        style          = 0;
        @(posedge aclk);
        forever begin
            if (hold_offs_done != hold_offs_wanted) begin
                // block fills up and has to stall its input
                hold_offs_done++;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    style    = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 9) != 0);
                    default: m_ready <= (seg_left % 4 == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[speed_line_parser_tier_select] ERROR");
        $finish;
    end

    initial begin
        int phase_end;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_func           <= OP_BYTE;
        s_rx_byte        <= 8'h00;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_HWY_ENTER;
        cfg_data         <= 8'h00;
        items_sent       = 0;
        burst_left       = 0;
        hold_offs_wanted = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: speed 0 on a tick drops city to slow
        push_item(OP_TICK, 8'hFF);
        // blank skip, sign, overflow to the negative limit, cr dropped
        append_str("SPEED: -99999");
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
        foreach (line_buf[i])
            push_item(OP_BYTE, line_buf[i]);
        line_buf.delete();
        push_item(OP_TICK, 8'h00);
        // zero byte inside the prefix, short line, no update
        append_str("SPE");
        line_buf.push_back(CHAR_NUL);
        line_buf.push_back(CHAR_LF);
        foreach (line_buf[i])
            push_item(OP_BYTE, line_buf[i]);
        line_buf.delete();
        push_item(OP_TICK, 8'hA5);

        // random phases, each under its own thresholds
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    // reset thresholds
                end
                1: retune(8'd0, 8'd0, 8'd0, 8'd0);
                2: retune(8'd255, 8'd255, 8'd255, 8'd255);
                3: retune(8'($urandom_range(0, 120)), 8'($urandom_range(0, 120)),
                          8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)));
                default: retune(HWY_ENTER_RST, HWY_EXIT_RST, SLOW_ENTER_RST, SLOW_EXIT_RST);
            endcase
            if (ph == 1 || ph == 3)
                hold_offs_wanted++;
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                send_random_line();
                // a few ticks between lines walk the tier toward the new speed
                repeat ($urandom_range(0, 3))
                    push_item(OP_TICK, 8'($urandom_range(0, 255)));
            end
        end

        quiesce();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("[speed_line_parser_tier_select] OK");
        else
            $display("[speed_line_parser_tier_select] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/slpts_pkg.sv
src/slpts_parser.sv
src/slpts_tier.sv
src/speed_line_parser_tier_select.sv
verif/slpts_tb_pkg.sv
verif/speed_tier_checker.sv
verif/tb_speed_line_parser_tier_select.sv
